>>> rtl/core/i2cws_pkg.sv
// Shared types, constants and helpers of the I2C write-frame sequencer.
`default_nettype none
package i2cws_pkg;

   // Widths of the counters and the request queue
   localparam int WAIT_BITS      = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Command codes on the request channel
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_COMMAND = 2'd1;
   localparam logic [1:0] CMD_DATA    = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_ADDR = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_WAIT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_WAIT   = 2'd2;

   // Reset values and frame constants
   localparam logic [7:0]  TARGET_ADDR_RESET = 8'h78;
   localparam logic [15:0] SHORT_WAIT_RESET  = 16'd32;
   localparam logic [15:0] LONG_WAIT_RESET   = 16'd64;
   localparam logic [7:0]  CTRL_COMMAND_BYTE = 8'h00;
   localparam logic [7:0]  CTRL_DATA_BYTE    = 8'h40;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_COMMAND = 2'd1,
      OP_DATA    = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] payload;
   } item_type;

   typedef enum logic [9:0] {
      PH_IDLE       = 10'b00_0000_0001,
      PH_START1     = 10'b00_0000_0010,
      PH_START2     = 10'b00_0000_0100,
      PH_BIT_SETUP  = 10'b00_0000_1000,
      PH_BIT_HIGH   = 10'b00_0001_0000,
      PH_ACK_SETUP  = 10'b00_0010_0000,
      PH_ACK_HIGH   = 10'b00_0100_0000,
      PH_STOP_SETUP = 10'b00_1000_0000,
      PH_STOP1      = 10'b01_0000_0000,
      PH_STOP2      = 10'b10_0000_0000
   } phase_type;

   // Clamp a wait register to the counter range
   function automatic logic [WAIT_BITS-1:0] sat_wait(input logic [15:0] ticks);
      logic [31:0] wide;
      wide = {16'd0, ticks};
      if ((wide >> WAIT_BITS) != 32'd0) begin
         return '1;
      end
      return WAIT_BITS'(wide);
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/i2cws_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface i2cws_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] payload;

   modport source (output valid, output command, output payload, input ready);
   modport sink (input valid, input command, input payload, output ready);
endinterface

interface i2cws_rsp_if;
   logic valid;
   logic ready;
   logic scl_level;
   logic sda_level;
   logic busy_res;
   logic refused;

   modport source (output valid, output scl_level, output sda_level, output busy_res,
                   output refused, input ready);
   modport sink (input valid, input scl_level, input sda_level, input busy_res,
                 input refused, output ready);
endinterface
`default_nettype wire

>>> rtl/core/i2c_write_frame_sequencer.sv
// Top level of the I2C write-frame sequencer.
// Drives SCL and SDA levels for a write-only I2C frame (start, address byte,
// control byte 0x00 or 0x40, payload byte, stop), timed by tick requests; each
// request yields exactly one response carrying the line levels, a busy flag and
// a refused flag for frame requests that arrive mid-frame. Requests are taken
// one per clock and responses leave one per clock while the response side is
// ready; a request's response passes the front register, the two-entry queue
// and the response register, and the sequencer in the back stage retires one
// request per cycle when the response register is free or being taken.
// Configuration writes (address byte, short and long wait) take effect at once
// and are meant for idle periods only.
`default_nettype none
module i2c_write_frame_sequencer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   i2cws_req_if.sink                                  req_chan,
   i2cws_rsp_if.source                                rsp_chan,
   input  wire logic                                  csr_wr_en,
   input  wire logic [i2cws_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [i2cws_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   i2cws_pkg::item_type push_item;
   logic                push_valid;
   logic                push_ready;
   i2cws_pkg::item_type pop_item;
   logic                pop_valid;
   logic                pop_ready;

   i2cws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   i2cws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   i2cws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_item  (pop_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

>>> rtl/core/i2cws_front.sv
// Front stage: accepts requests and classifies them into queue items.
`default_nettype none
module i2cws_front (
   input  wire logic              clock,
   input  wire logic              reset,
   i2cws_req_if.sink              req_chan,
   output i2cws_pkg::item_type    push_item,
   output logic                   push_valid,
   input  wire logic              push_ready
);

   logic                valid_ff;
   logic                valid_in;
   i2cws_pkg::item_type item_ff;
   i2cws_pkg::item_type item_in;
   logic                take;

   assign req_chan.ready = !valid_ff || push_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (valid_ff && push_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in        = 1'b1;
         item_in.payload = req_chan.payload;
         // the unused command code runs as a tick
         case (req_chan.command)
            i2cws_pkg::CMD_COMMAND: item_in.op = i2cws_pkg::OP_COMMAND;
            i2cws_pkg::CMD_DATA:    item_in.op = i2cws_pkg::OP_DATA;
            default:                item_in.op = i2cws_pkg::OP_TICK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule
`default_nettype wire

>>> rtl/core/i2cws_queue.sv
// Short queue of classified requests between front and back.
`default_nettype none
module i2cws_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire i2cws_pkg::item_type  push_item,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   output i2cws_pkg::item_type       pop_item,
   output logic                      pop_valid,
   input  wire logic                 pop_ready
);

   i2cws_pkg::item_type                      entry_ff [i2cws_pkg::QUEUE_DEPTH];
   logic [i2cws_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_ff;
   logic [i2cws_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_in;
   logic [i2cws_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_ff;
   logic [i2cws_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_in;
   logic [i2cws_pkg::QUEUE_CNT_BITS-1:0]     count_ff;
   logic [i2cws_pkg::QUEUE_CNT_BITS-1:0]     count_in;
   logic                                     push;
   logic                                     pop;

   localparam logic [i2cws_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
      i2cws_pkg::QUEUE_PTR_BITS'(i2cws_pkg::QUEUE_DEPTH - 1);
   localparam logic [i2cws_pkg::QUEUE_CNT_BITS-1:0] FULL_COUNT =
      i2cws_pkg::QUEUE_CNT_BITS'(i2cws_pkg::QUEUE_DEPTH);

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/i2cws_back.sv
// Back stage: frame sequencer, configuration registers and response register.
`default_nettype none
module i2cws_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire i2cws_pkg::item_type                   pop_item,
   input  wire logic                                  pop_valid,
   output logic                                       pop_ready,
   input  wire logic                                  csr_wr_en,
   input  wire logic [i2cws_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [i2cws_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   i2cws_rsp_if.source                                rsp_chan
);

   logic [7:0]                        addr_ff;
   logic [15:0]                       short_wait_ff;
   logic [15:0]                       long_wait_ff;

   i2cws_pkg::phase_type              phase_ff, phase_in;
   logic [1:0]                        byte_slot_ff, byte_slot_in;
   logic [3:0]                        bit_slot_ff, bit_slot_in;
   logic [i2cws_pkg::WAIT_BITS-1:0]   wait_ff, wait_in;
   logic [7:0]                        shift_ff, shift_in;
   logic [7:0]                        held_ff, held_in;
   logic                              is_data_ff, is_data_in;
   logic                              scl_ff, scl_in;
   logic                              sda_ff, sda_in;

   logic                              out_valid_ff, out_valid_in;
   logic                              out_busy_ff, out_busy_in;
   logic                              out_refused_ff, out_refused_in;

   logic                              pop;
   logic [1:0]                        next_slot;
   logic [7:0]                        next_byte;
   logic [7:0]                        shifted;
   logic [3:0]                        bit_next;

   assign pop_ready = !out_valid_ff || rsp_chan.ready;
   assign pop       = pop_valid && pop_ready;

   // Slot of the byte that a begin-byte step loads
   assign next_slot = (phase_ff == i2cws_pkg::PH_ACK_HIGH) ? byte_slot_ff + 2'd1 : 2'd0;
   assign shifted   = {shift_ff[6:0], 1'b0};
   assign bit_next  = bit_slot_ff + 4'd1;

   always_comb begin
      case (next_slot)
         2'd0:    next_byte = addr_ff;
         2'd1:    next_byte = is_data_ff ? i2cws_pkg::CTRL_DATA_BYTE
                                         : i2cws_pkg::CTRL_COMMAND_BYTE;
         default: next_byte = held_ff;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      byte_slot_in   = byte_slot_ff;
      bit_slot_in    = bit_slot_ff;
      wait_in        = wait_ff;
      shift_in       = shift_ff;
      held_in        = held_ff;
      is_data_in     = is_data_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      out_valid_in   = out_valid_ff;
      out_busy_in    = out_busy_ff;
      out_refused_in = out_refused_ff;

      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      if (pop) begin
         out_refused_in = 1'b0;
         if (pop_item.op == i2cws_pkg::OP_COMMAND || pop_item.op == i2cws_pkg::OP_DATA) begin
            if (phase_ff != i2cws_pkg::PH_IDLE) begin
               // drop a request that arrives mid-frame
               out_refused_in = 1'b1;
            end else begin
               held_in      = pop_item.payload;
               is_data_in   = (pop_item.op == i2cws_pkg::OP_DATA);
               byte_slot_in = 2'd0;
               bit_slot_in  = 4'd0;
               shift_in     = 8'd0;
               scl_in       = 1'b1;
               sda_in       = 1'b1;
               wait_in      = i2cws_pkg::sat_wait(long_wait_ff);
               phase_in     = i2cws_pkg::PH_START1;
            end
         end else if (phase_ff != i2cws_pkg::PH_IDLE) begin
            if (wait_ff > i2cws_pkg::WAIT_BITS'(1)) begin
               wait_in = wait_ff - 1'b1;
            end else begin
               case (phase_ff)
                  i2cws_pkg::PH_START1: begin
                     sda_in   = 1'b0;
                     wait_in  = i2cws_pkg::sat_wait(long_wait_ff);
                     phase_in = i2cws_pkg::PH_START2;
                  end
                  i2cws_pkg::PH_START2: begin
                     scl_in       = 1'b0;
                     byte_slot_in = next_slot;
                     bit_slot_in  = 4'd0;
                     shift_in     = next_byte;
                     sda_in       = next_byte[7];
                     wait_in      = i2cws_pkg::sat_wait(short_wait_ff);
                     phase_in     = i2cws_pkg::PH_BIT_SETUP;
                  end
                  i2cws_pkg::PH_BIT_SETUP: begin
                     scl_in   = 1'b1;
                     wait_in  = i2cws_pkg::sat_wait(short_wait_ff);
                     phase_in = i2cws_pkg::PH_BIT_HIGH;
                  end
                  i2cws_pkg::PH_BIT_HIGH: begin
                     scl_in      = 1'b0;
                     shift_in    = shifted;
                     bit_slot_in = bit_next;
                     wait_in     = i2cws_pkg::sat_wait(short_wait_ff);
                     if (bit_next < 4'd8) begin
                        sda_in   = shifted[7];
                        phase_in = i2cws_pkg::PH_BIT_SETUP;
                     end else begin
                        phase_in = i2cws_pkg::PH_ACK_SETUP;
                     end
                  end
                  i2cws_pkg::PH_ACK_SETUP: begin
                     scl_in   = 1'b1;
                     wait_in  = i2cws_pkg::sat_wait(short_wait_ff);
                     phase_in = i2cws_pkg::PH_ACK_HIGH;
                  end
                  i2cws_pkg::PH_ACK_HIGH: begin
                     scl_in = 1'b0;
                     if (byte_slot_ff < 2'd2) begin
                        byte_slot_in = next_slot;
                        bit_slot_in  = 4'd0;
                        shift_in     = next_byte;
                        sda_in       = next_byte[7];
                        wait_in      = i2cws_pkg::sat_wait(short_wait_ff);
                        phase_in     = i2cws_pkg::PH_BIT_SETUP;
                     end else begin
                        sda_in   = 1'b0;
                        wait_in  = i2cws_pkg::sat_wait(short_wait_ff);
                        phase_in = i2cws_pkg::PH_STOP_SETUP;
                     end
                  end
                  i2cws_pkg::PH_STOP_SETUP: begin
                     scl_in   = 1'b1;
                     wait_in  = i2cws_pkg::sat_wait(long_wait_ff);
                     phase_in = i2cws_pkg::PH_STOP1;
                  end
                  i2cws_pkg::PH_STOP1: begin
                     sda_in   = 1'b1;
                     wait_in  = i2cws_pkg::sat_wait(long_wait_ff);
                     phase_in = i2cws_pkg::PH_STOP2;
                  end
                  default: begin
                     phase_in = i2cws_pkg::PH_IDLE;
                     wait_in  = '0;
                  end
               endcase
            end
         end
         out_valid_in = 1'b1;
         out_busy_in  = (phase_in != i2cws_pkg::PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff        <= i2cws_pkg::TARGET_ADDR_RESET;
         short_wait_ff  <= i2cws_pkg::SHORT_WAIT_RESET;
         long_wait_ff   <= i2cws_pkg::LONG_WAIT_RESET;
         phase_ff       <= i2cws_pkg::PH_IDLE;
         byte_slot_ff   <= 2'd0;
         bit_slot_ff    <= 4'd0;
         wait_ff        <= '0;
         shift_ff       <= 8'd0;
         held_ff        <= 8'd0;
         is_data_ff     <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         out_valid_ff   <= 1'b0;
         out_busy_ff    <= 1'b0;
         out_refused_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               i2cws_pkg::CSR_TARGET_ADDR: addr_ff       <= csr_wdata[7:0];
               i2cws_pkg::CSR_SHORT_WAIT:  short_wait_ff <= csr_wdata[15:0];
               i2cws_pkg::CSR_LONG_WAIT:   long_wait_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
         phase_ff       <= phase_in;
         byte_slot_ff   <= byte_slot_in;
         bit_slot_ff    <= bit_slot_in;
         wait_ff        <= wait_in;
         shift_ff       <= shift_in;
         held_ff        <= held_in;
         is_data_ff     <= is_data_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         out_valid_ff   <= out_valid_in;
         out_busy_ff    <= out_busy_in;
         out_refused_ff <= out_refused_in;
      end
   end

   // The pin levels in the response are copies of the line levels, registered on pop only
   logic scl_out_ff;
   logic sda_out_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         scl_out_ff <= scl_in;
         sda_out_ff <= sda_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.scl_level = scl_out_ff;
   assign rsp_chan.sda_level = sda_out_ff;
   assign rsp_chan.busy_res  = out_busy_ff;
   assign rsp_chan.refused   = out_refused_ff;

endmodule
`default_nettype wire

>>> test/tb_i2c_write_frame_sequencer.sv
// Testbench for the I2C write-frame sequencer: random traffic checked against a line-level predictor.
`timescale 1ns / 1ps

module tb_i2c_write_frame_sequencer;

   // Unused command code, handled as a tick
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam longint WAIT_LIMIT = (64'd1 << i2cws_pkg::WAIT_BITS) - 1;
   localparam int PHASE_ITEMS = 190;
   localparam int MAX_SHOWN = 40;

   typedef struct packed {
      logic scl;
      logic sda;
      logic busy;
      logic refused;
   } line_state_type;

   class line_level_scoreboard;
      logic [7:0]                      addr_byte;
      logic [15:0]                     short_wait;
      logic [15:0]                     long_wait;
      i2cws_pkg::phase_type            phase;
      logic [1:0]                      byte_idx;
      logic [3:0]                      bit_idx;
      logic [i2cws_pkg::WAIT_BITS-1:0] wait_cnt;
      logic [7:0]                      shifter;
      logic [7:0]                      held_byte;
      logic                            data_frame;
      logic                            scl;
      logic                            sda;
      line_state_type                  expected_lines[$];
      int                              errors;

      function new();
         addr_byte   = i2cws_pkg::TARGET_ADDR_RESET;
         short_wait  = i2cws_pkg::SHORT_WAIT_RESET;
         long_wait   = i2cws_pkg::LONG_WAIT_RESET;
         phase       = i2cws_pkg::PH_IDLE;
         byte_idx    = '0;
         bit_idx     = '0;
         wait_cnt    = '0;
         shifter     = '0;
         held_byte   = '0;
         data_frame  = 1'b0;
         scl         = 1'b1;
         sda         = 1'b1;
         errors      = 0;
      endfunction

      function bit frame_active();
         return phase != i2cws_pkg::PH_IDLE;
      endfunction

      function void set_reg(logic [i2cws_pkg::CSR_INDEX_BITS-1:0] idx, logic [15:0] value);
         case (idx)
            i2cws_pkg::CSR_TARGET_ADDR: addr_byte = value[7:0];
            i2cws_pkg::CSR_SHORT_WAIT:  short_wait = value;
            i2cws_pkg::CSR_LONG_WAIT:   long_wait = value;
            default: ;
         endcase
      endfunction

      function void load_wait(logic [15:0] ticks);
         wait_cnt = (ticks > WAIT_LIMIT) ? WAIT_LIMIT[i2cws_pkg::WAIT_BITS-1:0] : ticks;
      endfunction

      function void start_byte(logic [1:0] slot);
         byte_idx = slot;
         bit_idx = '0;
         case (slot)
            2'd0:    shifter = addr_byte;
            2'd1:    shifter = data_frame ? i2cws_pkg::CTRL_DATA_BYTE
                                          : i2cws_pkg::CTRL_COMMAND_BYTE;
            default: shifter = held_byte;
         endcase
         sda = shifter[7];
         load_wait(short_wait);
         phase = i2cws_pkg::PH_BIT_SETUP;
      endfunction

      function void advance_tick();
         if (phase == i2cws_pkg::PH_IDLE) return;
         if (wait_cnt > 1) begin
            wait_cnt = wait_cnt - 1'b1;
            return;
         end
         case (phase)
            i2cws_pkg::PH_START1: begin
               sda = 1'b0;
               load_wait(long_wait);
               phase = i2cws_pkg::PH_START2;
            end
            i2cws_pkg::PH_START2: begin
               scl = 1'b0;
               start_byte(2'd0);
            end
            i2cws_pkg::PH_BIT_SETUP: begin
               scl = 1'b1;
               load_wait(short_wait);
               phase = i2cws_pkg::PH_BIT_HIGH;
            end
            i2cws_pkg::PH_BIT_HIGH: begin
               scl = 1'b0;
               shifter = shifter << 1;
               bit_idx = bit_idx + 1'b1;
               load_wait(short_wait);
               if (bit_idx < 4'd8) begin
                  sda = shifter[7];
                  phase = i2cws_pkg::PH_BIT_SETUP;
               end else begin
                  phase = i2cws_pkg::PH_ACK_SETUP;
               end
            end
            i2cws_pkg::PH_ACK_SETUP: begin
               scl = 1'b1;
               load_wait(short_wait);
               phase = i2cws_pkg::PH_ACK_HIGH;
            end
            i2cws_pkg::PH_ACK_HIGH: begin
               scl = 1'b0;
               if (byte_idx < 2'd2) begin
                  start_byte(byte_idx + 1'b1);
               end else begin
                  // stop: pull SDA low while SCL is low
                  sda = 1'b0;
                  load_wait(short_wait);
                  phase = i2cws_pkg::PH_STOP_SETUP;
               end
            end
            i2cws_pkg::PH_STOP_SETUP: begin
               scl = 1'b1;
               load_wait(long_wait);
               phase = i2cws_pkg::PH_STOP1;
            end
            i2cws_pkg::PH_STOP1: begin
               sda = 1'b1;
               load_wait(long_wait);
               phase = i2cws_pkg::PH_STOP2;
            end
            default: begin
               phase = i2cws_pkg::PH_IDLE;
               wait_cnt = '0;
            end
         endcase
      endfunction

      function void note_request(logic [1:0] cmd, logic [7:0] data);
         line_state_type lines;
         lines.refused = 1'b0;
         if (cmd == i2cws_pkg::CMD_COMMAND || cmd == i2cws_pkg::CMD_DATA) begin
            if (phase != i2cws_pkg::PH_IDLE) begin
               lines.refused = 1'b1;
            end else begin
               held_byte = data;
               data_frame = (cmd == i2cws_pkg::CMD_DATA);
               byte_idx = '0;
               bit_idx = '0;
               shifter = '0;
               scl = 1'b1;
               sda = 1'b1;
               load_wait(long_wait);
               phase = i2cws_pkg::PH_START1;
            end
         end else begin
            advance_tick();
         end
         lines.scl = scl;
         lines.sda = sda;
         lines.busy = (phase != i2cws_pkg::PH_IDLE);
         expected_lines.push_back(lines);
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_SHOWN) $display("Mismatch at %0t: %s", $time, what);
      endtask

      task check_response(logic scl_got, logic sda_got, logic busy_got, logic refused_got);
         line_state_type want;
         if (expected_lines.size() == 0) begin
            report("response with nothing expected");
            return;
         end
         want = expected_lines.pop_front();
         if (scl_got !== want.scl)
            report($sformatf("scl_level %b, expected %b", scl_got, want.scl));
         if (sda_got !== want.sda)
            report($sformatf("sda_level %b, expected %b", sda_got, want.sda));
         if (busy_got !== want.busy)
            report($sformatf("busy_res %b, expected %b", busy_got, want.busy));
         if (refused_got !== want.refused)
            report($sformatf("refused %b, expected %b", refused_got, want.refused));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [i2cws_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [i2cws_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   i2cws_req_if req_bus ();
   i2cws_rsp_if rsp_bus ();

   line_level_scoreboard sb = new();
   bit req_quiet = 1'b0;

   i2c_write_frame_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   initial begin
      #6_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
         sb.note_request(req_bus.command, req_bus.payload);
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_response(rsp_bus.scl_level, rsp_bus.sda_level, rsp_bus.busy_res,
                           rsp_bus.refused);
   end

   // Response side: random stalls, quiet stretches and one long hold-off
   initial begin
      int stall;
      int taken;
      bit quiet;
      bit pressed;
      taken = 0;
      quiet = 1'b0;
      pressed = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!pressed && taken >= 400) begin
            stall = 300;
            pressed = 1'b1;
         end else begin
            stall = quiet ? 0 : $urandom_range(0, 5);
         end
         if ($urandom_range(0, 39) == 0) quiet = !quiet;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         taken++;
      end
   end

   task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.payload <= data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic write_reg(input logic [i2cws_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.set_reg(idx, value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Drop the request line, then wait until every response is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_lines.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_payload();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Mostly whole frames: start one when idle, tick it through, with some refused noise
   task automatic send_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < (sb.frame_active() ? 3 : 50))
         send_item(($urandom_range(0, 1) == 0) ? i2cws_pkg::CMD_COMMAND : i2cws_pkg::CMD_DATA,
                   pick_payload());
      else if (r < (sb.frame_active() ? 12 : 60))
         send_item(CMD_SPARE, 8'($urandom));
      else
         send_item(i2cws_pkg::CMD_TICK, 8'($urandom));
   endtask

   // Tick until the predicted frame has ended, so registers change on an idle bus
   task automatic finish_frame();
      int guard;
      guard = 0;
      drain();
      while (sb.frame_active() && guard < 400) begin
         repeat (8) send_item(i2cws_pkg::CMD_TICK, 8'($urandom));
         drain();
         guard++;
      end
   endtask

   task automatic configure(input logic [7:0] addr, input logic [15:0] sw, input logic [15:0] lw);
      finish_frame();
      write_reg(i2cws_pkg::CSR_TARGET_ADDR, {8'h00, addr});
      write_reg(i2cws_pkg::CSR_SHORT_WAIT, sw);
      write_reg(i2cws_pkg::CSR_LONG_WAIT, lw);
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.command <= i2cws_pkg::CMD_TICK;
      req_bus.payload <= 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle ticks, spare code, a frame start and refused requests
      configure(8'hFF, 16'd1, 16'd1);
      send_item(i2cws_pkg::CMD_TICK, 8'h00);
      send_item(CMD_SPARE, 8'hFF);
      send_item(i2cws_pkg::CMD_COMMAND, 8'h81);
      send_item(i2cws_pkg::CMD_DATA, 8'hFF);
      send_item(CMD_SPARE, 8'h00);
      send_item(i2cws_pkg::CMD_COMMAND, 8'h00);
      repeat (12) send_item(i2cws_pkg::CMD_TICK, 8'hFF);
      send_item(i2cws_pkg::CMD_DATA, 8'h00);

      for (int k = 0; k < 8; k++) begin
         case (k)
            0:       configure(8'h00, 16'd0, 16'd0);
            1:       configure(8'h3C, 16'd1, 16'd2);
            2:       configure(8'h78, 16'd3, 16'd1);
            default: configure(8'($urandom), 16'($urandom_range(1, 4)),
                               16'($urandom_range(1, 6)));
         endcase
         repeat (PHASE_ITEMS) send_random_item();
      end

      // Longest waits last: the frame stays in its start hold until the end
      configure(8'h81, 16'hFFFF, 16'hFFFF);
      send_item(i2cws_pkg::CMD_DATA, 8'h5A);
      repeat (120) send_random_item();

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.expected_lines.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
